FILE: rtl/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types, codes and helpers for the timeline command sequencer.
// ----------------------------------------------------------------------------
package tcs_pkg;

  // input opcodes (carried on in_tuser)
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // result kinds (carried on out_tuser)
  localparam logic [1:0] KIND_RUN  = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;

  // timeline buffer layout
  localparam logic [15:0] HEADER_BYTES = 16'd12;
  localparam logic [15:0] ENTRY_BYTES  = 16'd5;

  // known command codes
  localparam logic [15:0] CMD_1      = 16'h0001;
  localparam logic [15:0] CMD_2      = 16'h0002;
  localparam logic [15:0] CMD_LOAD8  = 16'h000C;
  localparam logic [15:0] CMD_13     = 16'h000D;
  localparam logic [15:0] CMD_15     = 16'h000F;
  localparam logic [15:0] CMD_16     = 16'h0010;
  localparam logic [15:0] CMD_19     = 16'h0013;
  localparam logic [15:0] CMD_7FFF   = 16'h7FFF;
  localparam logic [15:0] CMD_8001   = 16'h8001;
  localparam logic [15:0] CMD_8002   = 16'h8002;

  localparam int COUNT_W = 9;

  // one table entry, first field in the high bits
  typedef struct packed {
    logic [7:0]  reps;
    logic [15:0] cmd;
    logic [15:0] delay;
  } entry_t;

  typedef struct packed {
    logic       known;
    logic [3:0] size;
  } psize_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_RD,
    ST_LOAD,
    ST_EVAL,
    ST_END
  } state_t;

  // parameter byte count of a command code
  function automatic psize_t param_size(input logic [15:0] code);
    psize_t r;
    r.known = 1'b1;
    r.size  = 4'd0;
    case (code)
      CMD_1, CMD_2, CMD_13, CMD_15, CMD_16, CMD_8001, CMD_8002: r.size = 4'd0;
      CMD_LOAD8:                                                r.size = 4'd8;
      CMD_19, CMD_7FFF:                                         r.size = 4'd4;
      default:                                                  r.known = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/tcs_ram.sv
// ----------------------------------------------------------------------------
// tcs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcs_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/timeline_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// timeline_command_sequencer_top
// Frame-timed command sequencer: walks a table of command entries on each
// frame tick and emits one beat per command run plus an end-of-tick beat.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata / payload                         | tuser  | tlast
//  --------+-----+-----------------------------------------+--------+------
//  in_     | in  | index, delay, command, repeats          | opcode | -
//  out_    | out | command, offset, frame, run, bad, ovr   | kind   | last
//  cfg_    | in  | command_count (write enable + data)     | -      | -
//
//  Steps: a write passes IDLE, ACK; a tick passes IDLE, RD, EVAL to fetch the
//  entry at the cursor, runs commands from EVAL, steps over entries via LOAD.
//  All table reads go through the registered read port of the entry RAM.
//  Reset: control state and counters clear; the entry table is not cleared.
//  Stalls: the walk holds whenever a beat is due and the output register is full and not taken;
//  a new input beat is taken only once the previous one is fully handled.
// ----------------------------------------------------------------------------
module timeline_command_sequencer_top #(
  parameter int MAX_COMMANDS      = 256,
  parameter int MAX_RUNS_PER_TICK = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // entry_index[7:0], entry_delay[15:0],
                                  // entry_command[15:0], entry_repeats[7:0]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // run_command[15:0], param_offset[15:0],
                                  // frame_number[31:0], running, bad_command,
                                  // overrun, zero pad[4:0]
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast,
  // configuration
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata   // command_count
);

  localparam int AW = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
  localparam int RW = $clog2(MAX_RUNS_PER_TICK + 1);
  localparam int CW = tcs_pkg::COUNT_W;

  // input field split
  logic [7:0]  in_index;
  logic [15:0] in_delay;
  logic [15:0] in_cmd;
  logic [7:0]  in_reps;
  assign in_index = in_tdata[7:0];
  assign in_delay = in_tdata[23:8];
  assign in_cmd   = in_tdata[39:24];
  assign in_reps  = in_tdata[47:40];

  // control and timeline state
  tcs_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r;
  logic [15:0]     cursor_r, cursor_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [7:0]      reps_r, reps_nxt;
  logic [31:0]     frame_r, frame_nxt;
  logic [31:0]     last_run_r, last_run_nxt;
  logic            active_r, active_nxt;
  logic            failed_r, failed_nxt;
  logic [RW-1:0]   runs_r, runs_nxt;
  logic            ovr_r, ovr_nxt;

  // output register
  logic            out_valid_r;
  logic [71:0]     out_data_r;
  logic [1:0]      out_kind_r;
  logic            out_last_r;
  logic            out_load;
  logic [1:0]      out_kind_nxt;
  logic [15:0]     out_cmd_nxt;
  logic [15:0]     out_off_nxt;
  logic            out_ovr_nxt;
  logic            out_last_nxt;
  logic            out_free;

  // entry RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  tcs_pkg::entry_t   ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [$bits(tcs_pkg::entry_t)-1:0] ram_rdata;
  tcs_pkg::entry_t   ent;

  tcs_ram #(
    .WIDTH ($bits(tcs_pkg::entry_t)),
    .DEPTH (MAX_COMMANDS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent = tcs_pkg::entry_t'(ram_rdata);

  // effective entry count
  logic [CW-1:0] limit;
  assign limit = (32'(count_r) > MAX_COMMANDS) ? CW'(MAX_COMMANDS) : count_r;

  // entry decode terms
  tcs_pkg::psize_t psz;
  logic [CW-1:0]   pos_inc;
  logic [31:0]     since_run;
  logic            delay_blocks;
  assign psz          = tcs_pkg::param_size(ent.cmd);
  assign pos_inc      = pos_r + CW'(1);
  assign since_run    = frame_r - last_run_r;
  assign delay_blocks = since_run < {16'd0, ent.delay};

  assign in_tready = (state_r == tcs_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tcs_pkg::ST_IDLE;
      cursor_r   <= tcs_pkg::HEADER_BYTES;
      pos_r      <= '0;
      reps_r     <= '0;
      frame_r    <= '0;
      last_run_r <= '0;
      active_r   <= 1'b0;
      failed_r   <= 1'b0;
      runs_r     <= '0;
      ovr_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cursor_r   <= cursor_nxt;
      pos_r      <= pos_nxt;
      reps_r     <= reps_nxt;
      frame_r    <= frame_nxt;
      last_run_r <= last_run_nxt;
      active_r   <= active_nxt;
      failed_r   <= failed_nxt;
      runs_r     <= runs_nxt;
      ovr_r      <= ovr_nxt;
    end
  end

  // sequencer: next state, RAM access and result beats
  always_comb begin
    state_nxt    = state_r;
    cursor_nxt   = cursor_r;
    pos_nxt      = pos_r;
    reps_nxt     = reps_r;
    frame_nxt    = frame_r;
    last_run_nxt = last_run_r;
    active_nxt   = active_r;
    failed_nxt   = failed_r;
    runs_nxt     = runs_r;
    ovr_nxt      = ovr_r;

    ram_we    = 1'b0;
    ram_waddr = AW'(in_index);
    ram_wdata = '{reps: in_reps, cmd: in_cmd, delay: in_delay};
    ram_re    = 1'b0;
    ram_raddr = AW'(pos_r);

    out_load     = 1'b0;
    out_kind_nxt = tcs_pkg::KIND_RUN;
    out_cmd_nxt  = '0;
    out_off_nxt  = '0;
    out_ovr_nxt  = 1'b0;
    out_last_nxt = 1'b0;

    case (state_r)
      tcs_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            tcs_pkg::OP_WRITE: begin
              ram_we    = (32'(in_index) < MAX_COMMANDS);
              state_nxt = tcs_pkg::ST_ACK;
            end
            tcs_pkg::OP_START: begin
              // rewind with the frame set to one, then walk the table as a tick
              frame_nxt    = 32'd1;
              last_run_nxt = '0;
              cursor_nxt   = tcs_pkg::HEADER_BYTES;
              pos_nxt      = '0;
              failed_nxt   = 1'b0;
              runs_nxt     = '0;
              ovr_nxt      = 1'b0;
              if (limit == '0) begin
                reps_nxt   = '0;
                active_nxt = 1'b0;
                state_nxt  = tcs_pkg::ST_END;
              end else begin
                active_nxt = 1'b1;
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_nxt  = tcs_pkg::ST_LOAD;
              end
            end
            tcs_pkg::OP_TICK: begin
              runs_nxt = '0;
              ovr_nxt  = 1'b0;
              if (active_r) begin
                frame_nxt = frame_r + 32'd1;
                state_nxt = tcs_pkg::ST_RD;
              end else begin
                state_nxt = tcs_pkg::ST_END;
              end
            end
            default: begin
              state_nxt = tcs_pkg::ST_IDLE;
            end
          endcase
        end
      end

      tcs_pkg::ST_ACK: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_nxt = tcs_pkg::KIND_ACK;
          out_last_nxt = 1'b1;
          state_nxt    = tcs_pkg::ST_IDLE;
        end
      end

      // fetch the entry under the cursor
      tcs_pkg::ST_RD: begin
        if (pos_r >= limit) begin
          active_nxt = 1'b0;
          state_nxt  = tcs_pkg::ST_END;
        end else begin
          ram_re    = 1'b1;
          state_nxt = tcs_pkg::ST_EVAL;
        end
      end

      // new entry arrived: take its repeat count
      tcs_pkg::ST_LOAD: begin
        reps_nxt  = ent.reps;
        state_nxt = tcs_pkg::ST_EVAL;
      end

      tcs_pkg::ST_EVAL: begin
        if (reps_r == '0) begin
          // entry exhausted: skip over it
          if (!psz.known) begin
            failed_nxt = 1'b1;
            active_nxt = 1'b0;
            state_nxt  = tcs_pkg::ST_END;
          end else begin
            cursor_nxt = cursor_r + tcs_pkg::ENTRY_BYTES + {12'd0, psz.size};
            pos_nxt    = pos_inc;
            if (pos_inc >= limit) begin
              active_nxt = 1'b0;
              state_nxt  = tcs_pkg::ST_END;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = AW'(pos_inc);
              state_nxt = tcs_pkg::ST_LOAD;
            end
          end
        end else if (delay_blocks) begin
          state_nxt = tcs_pkg::ST_END;
        end else if (!psz.known) begin
          failed_nxt = 1'b1;
          active_nxt = 1'b0;
          state_nxt  = tcs_pkg::ST_END;
        end else if (32'(runs_r) >= MAX_RUNS_PER_TICK) begin
          ovr_nxt   = 1'b1;
          state_nxt = tcs_pkg::ST_END;
        end else if (out_free) begin
          // run the command
          out_load     = 1'b1;
          out_kind_nxt = tcs_pkg::KIND_RUN;
          out_cmd_nxt  = ent.cmd;
          out_off_nxt  = cursor_r + tcs_pkg::ENTRY_BYTES;
          runs_nxt     = runs_r + RW'(1);
          last_run_nxt = frame_r;
          reps_nxt     = reps_r - 8'd1;
        end
      end

      tcs_pkg::ST_END: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_nxt = tcs_pkg::KIND_TICK;
          out_ovr_nxt  = ovr_r;
          out_last_nxt = 1'b1;
          state_nxt    = tcs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tcs_pkg::ST_IDLE;
      end
    endcase
  end

  // output register; status reflects the state in force when the beat forms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {5'd0, out_ovr_nxt, failed_nxt, active_nxt, frame_r,
                     out_off_nxt, out_cmd_nxt};
      out_kind_r <= out_kind_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // checks
  a_active_failed_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(active_r && failed_r))
    else $error("sequencer both active and failed");

  a_runs_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(runs_r) <= MAX_RUNS_PER_TICK)
    else $error("run count above per-tick limit");

  a_run_while_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_kind_nxt == tcs_pkg::KIND_RUN) |-> (active_r && reps_r != '0))
    else $error("command run emitted while stopped or without repeats");

  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == tcs_pkg::ST_IDLE && !ram_re))
    else $error("table write outside idle");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result overwrote a pending beat");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timeline command sequencer. A directed table
// covers stopped ticks, the empty table, entry writes at the field extremes,
// zero-repeat entries, delay blocking, a bad command code, the per-tick run
// limit and an oversize command_count. Random phases then change
// command_count and send write, start and tick beats. A guard runs a copy of
// the predictor first, so the walk never reaches a table slot that was never
// written. Every result beat is compared field by field with the predicted
// stream, under random input gaps, output stalls and one long output hold.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TABLE_DEPTH   = 256;
  localparam int RUN_LIMIT     = 63;
  localparam int RANDOM_ITEMS  = 135;
  localparam int HOLD_AT       = 40;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_CYCLES  = 60;
  localparam int LIMIT_CYCLES  = 2000000;

  // opcode that the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  idx;
    logic [15:0] delay;
    logic [15:0] cmd;
    logic [7:0]  reps;
  } stim_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] cmd;
    logic [15:0] offset;
    logic [31:0] frame;
    logic        running;
    logic        bad;
    logic        ovr;
    logic        last;
  } result_t;

  typedef struct packed {
    stim_beat_t  beat;
    logic        has_count;
    logic [8:0]  count;
    logic        typed;
    logic [1:0]  want_kind;
    logic [31:0] want_frame;
    logic        want_running;
    logic        want_bad;
  } stim_row_t;

  typedef struct packed {
    logic [8:0]  count;
    logic [15:0] cursor;
    logic [8:0]  pos;
    logic [7:0]  reps_left;
    logic [31:0] frame;
    logic [31:0] last_run;
    logic        active;
    logic        failed;
  } timeline_state_t;

  // DUT ports
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic [8:0]  cfg_wdata  = '0;

  // predictor state
  logic [15:0]     entry_delay_mem [TABLE_DEPTH];
  logic [15:0]     entry_cmd_mem   [TABLE_DEPTH];
  logic [7:0]      entry_reps_mem  [TABLE_DEPTH];
  bit              entry_written   [TABLE_DEPTH];
  timeline_state_t tl_state;
  result_t         step_beats[$];
  result_t         pending_results[$];
  stim_row_t       directed_rows[$];

  // bookkeeping
  int          fail_count    = 0;
  int          beats_in      = 0;
  int          beats_out     = 0;
  int          run_beats     = 0;
  int          overrun_ticks = 0;
  int          bad_ticks     = 0;
  int          count_writes  = 0;
  int          burst_left    = 0;
  bit          hold_request  = 1'b0;
  bit          hold_done     = 1'b0;
  int unsigned cycle_count   = 0;
  result_t     head_result;

  timeline_command_sequencer_top #(
    .MAX_COMMANDS      (TABLE_DEPTH),
    .MAX_RUNS_PER_TICK (RUN_LIMIT)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // parameter bytes that follow a command code; -1 for an unknown code
  function automatic int param_bytes(input logic [15:0] code);
    case (code)
      tcs_pkg::CMD_1, tcs_pkg::CMD_2, tcs_pkg::CMD_13, tcs_pkg::CMD_15,
      tcs_pkg::CMD_16, tcs_pkg::CMD_8001, tcs_pkg::CMD_8002: return 0;
      tcs_pkg::CMD_LOAD8:                                    return 8;
      tcs_pkg::CMD_19, tcs_pkg::CMD_7FFF:                    return 4;
      default:                                               return -1;
    endcase
  endfunction

  function automatic int walk_limit(input logic [8:0] count);
    return (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
  endfunction

  function automatic result_t make_result(input logic [1:0] kind, input logic [15:0] cmd,
                                          input logic [15:0] offset, input logic ovr,
                                          input logic last, input timeline_state_t st);
    result_t r;
    r.kind    = kind;
    r.cmd     = cmd;
    r.offset  = offset;
    r.frame   = st.frame;
    r.running = st.active;
    r.bad     = st.failed;
    r.ovr     = ovr;
    r.last    = last;
    return r;
  endfunction

  // one frame tick: advance the frame, run every due command, then end of tick
  task automatic run_tick(inout timeline_state_t st, inout int miss_idx);
    int          runs;
    int          psz;
    logic        ovr;
    logic        done;
    logic [15:0] code;
    runs = 0;
    ovr  = 1'b0;
    done = 1'b0;
    if (st.active) begin
      st.frame = st.frame + 32'd1;
      while (st.active && !done) begin
        if (st.pos >= walk_limit(st.count)) begin
          st.active = 1'b0;
        end else if (!entry_written[st.pos[7:0]]) begin
          if (miss_idx < 0) miss_idx = int'(st.pos);
          done = 1'b1;
        end else begin
          code = entry_cmd_mem[st.pos[7:0]];
          psz  = param_bytes(code);
          if (st.reps_left == 0) begin
            // entry used up: skip it and load the next repeat count
            if (psz < 0) begin
              st.failed = 1'b1;
              st.active = 1'b0;
            end else begin
              st.cursor = st.cursor + tcs_pkg::ENTRY_BYTES + 16'(psz);
              st.pos    = st.pos + 9'd1;
              if (st.pos >= walk_limit(st.count)) begin
                st.active = 1'b0;
              end else if (!entry_written[st.pos[7:0]]) begin
                if (miss_idx < 0) miss_idx = int'(st.pos);
                done = 1'b1;
              end else begin
                st.reps_left = entry_reps_mem[st.pos[7:0]];
              end
            end
          end else if ((st.frame - st.last_run) <
                       {16'd0, entry_delay_mem[st.pos[7:0]]}) begin
            done = 1'b1;
          end else if (psz < 0) begin
            st.failed = 1'b1;
            st.active = 1'b0;
          end else if (runs >= RUN_LIMIT) begin
            ovr  = 1'b1;
            done = 1'b1;
          end else begin
            step_beats.push_back(make_result(tcs_pkg::KIND_RUN, code,
                                             st.cursor + tcs_pkg::ENTRY_BYTES,
                                             1'b0, 1'b0, st));
            runs         = runs + 1;
            st.last_run  = st.frame;
            st.reps_left = st.reps_left - 8'd1;
          end
        end
      end
    end
    step_beats.push_back(make_result(tcs_pkg::KIND_TICK, 16'd0, 16'd0, ovr, 1'b1, st));
  endtask

  // result beats of one input beat into step_beats; miss_idx flags an
  // unwritten slot that the walk would read
  task automatic predict_beats(input stim_beat_t b, inout timeline_state_t st,
                               output int miss_idx);
    step_beats.delete();
    miss_idx = -1;
    case (b.op)
      tcs_pkg::OP_WRITE: begin
        entry_delay_mem[b.idx] = b.delay;
        entry_cmd_mem[b.idx]   = b.cmd;
        entry_reps_mem[b.idx]  = b.reps;
        entry_written[b.idx]   = 1'b1;
        step_beats.push_back(make_result(tcs_pkg::KIND_ACK, 16'd0, 16'd0, 1'b0, 1'b1, st));
      end
      tcs_pkg::OP_START: begin
        st.frame    = '0;
        st.last_run = '0;
        st.cursor   = tcs_pkg::HEADER_BYTES;
        st.pos      = '0;
        st.failed   = 1'b0;
        if (walk_limit(st.count) == 0) begin
          st.reps_left = '0;
          st.active    = 1'b0;
          st.frame     = 32'd1;
        end else begin
          if (!entry_written[0]) miss_idx = 0;
          st.reps_left = entry_reps_mem[0];
          st.active    = 1'b1;
        end
        if (miss_idx < 0) run_tick(st, miss_idx);
      end
      tcs_pkg::OP_TICK: run_tick(st, miss_idx);
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_row(input logic [1:0] op, input logic [7:0] idx,
                         input logic [15:0] delay, input logic [15:0] cmd,
                         input logic [7:0] reps, input int count = -1,
                         input int want_frame = -1,
                         input logic [1:0] want_kind = tcs_pkg::KIND_ACK,
                         input logic want_running = 1'b0, input logic want_bad = 1'b0);
    stim_row_t r;
    r.beat         = '{op: op, idx: idx, delay: delay, cmd: cmd, reps: reps};
    r.has_count    = (count >= 0);
    r.count        = 9'(count);
    r.typed        = (want_frame >= 0);
    r.want_kind    = want_kind;
    r.want_frame   = 32'(want_frame);
    r.want_running = want_running;
    r.want_bad     = want_bad;
    directed_rows.push_back(r);
  endtask

  function automatic logic [15:0] pick_code();
    if ($urandom_range(0, 99) >= 85) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 9))
      0:       return tcs_pkg::CMD_1;
      1:       return tcs_pkg::CMD_2;
      2:       return tcs_pkg::CMD_LOAD8;
      3:       return tcs_pkg::CMD_13;
      4:       return tcs_pkg::CMD_15;
      5:       return tcs_pkg::CMD_16;
      6:       return tcs_pkg::CMD_19;
      7:       return tcs_pkg::CMD_7FFF;
      8:       return tcs_pkg::CMD_8001;
      default: return tcs_pkg::CMD_8002;
    endcase
  endfunction

  function automatic stim_beat_t random_entry_beat(input logic [7:0] idx);
    stim_beat_t b;
    int         r;
    b.op  = tcs_pkg::OP_WRITE;
    b.idx = idx;
    b.cmd = pick_code();
    r = $urandom_range(0, 19);
    if (r <= 10)      b.delay = 16'd0;
    else if (r <= 15) b.delay = 16'($urandom_range(1, 3));
    else if (r <= 18) b.delay = 16'($urandom_range(0, 65535));
    else              b.delay = 16'hFFFF;
    r = $urandom_range(0, 19);
    if (r <= 2)       b.reps = 8'd0;
    else if (r <= 13) b.reps = 8'($urandom_range(1, 3));
    else if (r <= 16) b.reps = 8'($urandom_range(4, 20));
    else              b.reps = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // offer one beat, wait for the handshake, predict, then maybe leave a gap
  task automatic send_beat(input stim_beat_t b, input logic typed, input result_t typed_res);
    int miss;
    int gap;
    in_tdata  <= {b.reps, b.cmd, b.delay, b.idx};
    in_tuser  <= b.op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    beats_in = beats_in + 1;
    predict_beats(b, tl_state, miss);
    if (miss >= 0) begin
      $error("stimulus reached unwritten table slot %0d", miss);
      fail_count = fail_count + 1;
    end
    if (typed) pending_results.push_back(typed_res);
    else foreach (step_beats[i]) pending_results.push_back(step_beats[i]);
    // bursts of random length, sometimes long ones, with gaps between them
    if (burst_left > 0) burst_left = burst_left - 1;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // command_count is only written with nothing in flight
  task automatic set_count(input logic [8:0] value);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we         <= 1'b0;
    tl_state.count  = value;
    count_writes    = count_writes + 1;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count = fail_count + 1;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      beats_out = beats_out + 1;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: kind %0d tdata 0x%0h",
               out_tuser, out_tdata);
        fail_count = fail_count + 1;
      end else begin
        head_result = pending_results.pop_front();
        check_field("kind",         32'(head_result.kind),    32'(out_tuser));
        check_field("run_command",  32'(head_result.cmd),     32'(out_tdata[15:0]));
        check_field("param_offset", 32'(head_result.offset),  32'(out_tdata[31:16]));
        check_field("frame_number", head_result.frame,        out_tdata[63:32]);
        check_field("running",      32'(head_result.running), 32'(out_tdata[64]));
        check_field("bad_command",  32'(head_result.bad),     32'(out_tdata[65]));
        check_field("overrun",      32'(head_result.ovr),     32'(out_tdata[66]));
        check_field("last",         32'(head_result.last),    32'(out_tlast));
        if (head_result.kind == tcs_pkg::KIND_RUN) run_beats = run_beats + 1;
        if (head_result.kind == tcs_pkg::KIND_TICK && head_result.ovr)
          overrun_ticks = overrun_ticks + 1;
        if (head_result.kind == tcs_pkg::KIND_TICK && head_result.bad)
          bad_ticks = bad_ticks + 1;
      end
    end
  end

  // receiver: changing stall patterns, plus one long hold on request
  initial begin : receiver
    int mode;
    int span;
    forever begin
      if (hold_request && !hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 60);
        repeat (span) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom_range(0, 1));
            2:       out_tready <= ($urandom_range(0, 3) == 0);
            default: out_tready <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_beat_t      b;
    result_t         typed_res;
    timeline_state_t trial;
    int              miss;
    int              random_beats;
    int              phase;
    int              plen;
    int              lim;
    int              r;
    logic [8:0]      count;

    tl_state = '{count: '0, cursor: tcs_pkg::HEADER_BYTES, pos: '0, reps_left: '0,
                 frame: '0, last_run: '0, active: 1'b0, failed: 1'b0};
    foreach (entry_written[i]) entry_written[i] = 1'b0;

    //      op                 idx     delay     command             reps   count frame kind
    add_row(tcs_pkg::OP_TICK,  8'd0,   16'd0,    16'd0,              8'd0,  -1, 0,
            tcs_pkg::KIND_TICK);
    add_row(tcs_pkg::OP_START, 8'd0,   16'd0,    16'd0,              8'd0,  -1, 1,
            tcs_pkg::KIND_TICK);
    add_row(tcs_pkg::OP_WRITE, 8'd0,   16'd0,    tcs_pkg::CMD_1,     8'd2,  -1, 1,
            tcs_pkg::KIND_ACK);
    add_row(tcs_pkg::OP_WRITE, 8'd1,   16'd1,    tcs_pkg::CMD_LOAD8, 8'd1,  -1, 1,
            tcs_pkg::KIND_ACK);
    add_row(tcs_pkg::OP_WRITE, 8'd2,   16'd0,    tcs_pkg::CMD_19,    8'd0,  -1, 1,
            tcs_pkg::KIND_ACK);
    add_row(tcs_pkg::OP_WRITE, 8'd3,   16'd0,    tcs_pkg::CMD_8002,  8'd3,  -1, 1,
            tcs_pkg::KIND_ACK);
    add_row(tcs_pkg::OP_WRITE, 8'd4,   16'd2,    16'hFFFF,           8'd1,  -1, 1,
            tcs_pkg::KIND_ACK);
    add_row(tcs_pkg::OP_WRITE, 8'd255, 16'hFFFF, tcs_pkg::CMD_7FFF,  8'hFF, -1, 1,
            tcs_pkg::KIND_ACK);
    // walk of five entries; ends on the unknown code in slot 4
    add_row(tcs_pkg::OP_START, 8'd0,   16'd0,    16'd0,              8'd0,  5);
    add_row(tcs_pkg::OP_TICK,  8'd0,   16'd0,    16'd0,              8'd0);
    add_row(tcs_pkg::OP_TICK,  8'd0,   16'd0,    16'd0,              8'd0);
    add_row(tcs_pkg::OP_TICK,  8'd0,   16'd0,    16'd0,              8'd0);
    add_row(tcs_pkg::OP_TICK,  8'd0,   16'd0,    16'd0,              8'd0);
    add_row(OP_UNUSED,         8'hA5,  16'h5A5A, 16'hA5A5,           8'h5A);
    add_row(tcs_pkg::OP_WRITE, 8'd4,   16'd0,    tcs_pkg::CMD_8001,  8'd1);
    add_row(tcs_pkg::OP_START, 8'd0,   16'd0,    16'd0,              8'd0);
    // one entry repeated past the per-tick run limit
    add_row(tcs_pkg::OP_WRITE, 8'd0,   16'd0,    tcs_pkg::CMD_8001,  8'd200, 1);
    add_row(tcs_pkg::OP_START, 8'd0,   16'd0,    16'd0,              8'd0);
    add_row(tcs_pkg::OP_TICK,  8'd0,   16'd0,    16'd0,              8'd0);
    add_row(tcs_pkg::OP_TICK,  8'd0,   16'd0,    16'd0,              8'd0);
    add_row(tcs_pkg::OP_TICK,  8'd0,   16'd0,    16'd0,              8'd0);
    // oversize count with the first entry blocked for good
    add_row(tcs_pkg::OP_WRITE, 8'd0,   16'hFFFF, tcs_pkg::CMD_16,    8'd1,  511);
    add_row(tcs_pkg::OP_START, 8'd0,   16'd0,    16'd0,              8'd0);
    add_row(tcs_pkg::OP_TICK,  8'd0,   16'd0,    16'd0,              8'd0);
    add_row(tcs_pkg::OP_TICK,  8'd0,   16'd0,    16'd0,              8'd0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].has_count) set_count(directed_rows[i].count);
      typed_res = '{kind: directed_rows[i].want_kind, cmd: '0, offset: '0,
                    frame: directed_rows[i].want_frame,
                    running: directed_rows[i].want_running,
                    bad: directed_rows[i].want_bad, ovr: 1'b0, last: 1'b1};
      send_beat(directed_rows[i].beat, directed_rows[i].typed, typed_res);
    end

    // random phases, each under its own command_count
    random_beats = 0;
    phase        = 0;
    while (random_beats < RANDOM_ITEMS) begin
      case (phase)
        0: count = 9'd0;
        1: count = 9'd256;
        2: count = 9'd511;
        3: count = 9'd1;
        default: begin
          r = $urandom_range(0, 9);
          if (r < 6)       count = 9'($urandom_range(2, 8));
          else if (r < 8)  count = 9'($urandom_range(9, 40));
          else if (r == 8) count = 9'($urandom_range(0, 511));
          else             count = 9'd256;
        end
      endcase
      set_count(count);
      lim  = walk_limit(count);
      plen = $urandom_range(8, 20);
      for (int k = 0; k < plen && random_beats < RANDOM_ITEMS; k++) begin
        b = stim_beat_t'({$urandom(), $urandom()});
        r = $urandom_range(0, 99);
        if (k == 0 || (r >= 82 && r < 92)) begin
          b.op = tcs_pkg::OP_START;
        end else if (r < 55) begin
          b.op = tcs_pkg::OP_TICK;
        end else if (r < 82) begin
          if (lim > 0 && $urandom_range(0, 9) < 7)
            b = random_entry_beat(8'($urandom_range(0, lim - 1)));
          else
            b = random_entry_beat(8'($urandom_range(0, 255)));
        end else begin
          b.op = OP_UNUSED;
        end
        // a walk that would read a never-written slot fills that slot first
        if (b.op == tcs_pkg::OP_START || b.op == tcs_pkg::OP_TICK) begin
          trial = tl_state;
          predict_beats(b, trial, miss);
          if (miss >= 0) b = random_entry_beat(8'(miss));
        end
        if (random_beats == HOLD_AT) hold_request = 1'b1;
        send_beat(b, 1'b0, '0);
        if (b.op != OP_UNUSED) random_beats = random_beats + 1;
      end
      phase = phase + 1;
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input beats over %0d command_count settings; checked %0d result beats.",
             beats_in, count_writes, beats_out);
    $display("Saw %0d command runs, %0d ticks cut at the run limit, %0d ticks after a bad code.",
             run_beats, overrun_ticks, bad_ticks);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
